/* rtl/csfs_pkg.sv */
// Shared types, constants and AES-128 helper functions for the CCM* frame
// security block. Used by every module under rtl; depends on nothing.
`timescale 1ns / 1ps

package csfs_pkg;

    // One 16-byte block, byte 0 most significant
    typedef logic [0:15][7:0] blk_t;

    // Result item kinds
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_TAG     = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    // Register indexes on the configuration port
    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    // Last AES round number
    localparam logic [3:0] AES_ROUNDS = 4'd10;

    // Role of one frame byte
    typedef enum logic [1:0] {
        CLS_HDR,
        CLS_PAY,
        CLS_TAG,
        CLS_SKIP
    } cls_t;

    // One queued byte, with the frame fields when it opens a frame
    typedef struct packed {
        logic        start;
        logic        dir;
        logic [2:0]  level;
        logic [63:0] src;
        logic [31:0] fc;
        logic [6:0]  hlen;
        logic [6:0]  plen;
        cls_t        cls;
        logic [6:0]  idx;
        logic [7:0]  data;
        logic        fin;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MASK,
        ST_B0,
        ST_BYTE,
        ST_FLUSH,
        ST_KS,
        ST_MACW,
        ST_FIN,
        ST_FINW,
        ST_TAG,
        ST_VERD
    } bstate_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // Tag length in bytes from the low level bits
    function automatic logic [4:0] tag_bytes(input logic [1:0] lv);
        logic [4:0] m;
        case (lv)
            2'd1:    m = 5'd4;
            2'd2:    m = 5'd8;
            2'd3:    m = 5'd16;
            default: m = 5'd0;
        endcase
        return m;
    endfunction

    // Counter block: flags 1, source, counter, level, block number
    function automatic blk_t make_ctr(input logic [63:0] src, input logic [31:0] fc,
                                      input logic [2:0] lv, input logic [15:0] n);
        blk_t b;
        b[0] = 8'h01;
        for (int i = 0; i < 8; i++) b[1 + i] = src[56 - 8 * i +: 8];
        for (int i = 0; i < 4; i++) b[9 + i] = fc[24 - 8 * i +: 8];
        b[13] = {5'd0, lv};
        b[14] = n[15:8];
        b[15] = n[7:0];
        return b;
    endfunction

    // Next round key from the current one
    function automatic blk_t key_next(input blk_t rk, input logic [7:0] rcon);
        blk_t w;
        logic [0:3][7:0] t;
        t[0] = SBOX[rk[13]] ^ rcon;
        t[1] = SBOX[rk[14]];
        t[2] = SBOX[rk[15]];
        t[3] = SBOX[rk[12]];
        for (int j = 0; j < 4; j++) w[j] = rk[j] ^ t[j];
        for (int i = 4; i < 16; i++) w[i] = rk[i] ^ w[i - 4];
        return w;
    endfunction

    // One AES round: sub bytes, shift rows, mix columns unless last, add key
    function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic last_rnd);
        blk_t t;
        blk_t r;
        logic [7:0] a0, a1, a2, a3, x;
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                t[c * 4 + j] = SBOX[s[((c + j) % 4) * 4 + j]];
        r = t;
        if (!last_rnd) begin
            for (int c = 0; c < 4; c++) begin
                a0 = t[c * 4];
                a1 = t[c * 4 + 1];
                a2 = t[c * 4 + 2];
                a3 = t[c * 4 + 3];
                x  = a0 ^ a1 ^ a2 ^ a3;
                r[c * 4]     = a0 ^ x ^ xtime(a0 ^ a1);
                r[c * 4 + 1] = a1 ^ x ^ xtime(a1 ^ a2);
                r[c * 4 + 2] = a2 ^ x ^ xtime(a2 ^ a3);
                r[c * 4 + 3] = a3 ^ x ^ xtime(a3 ^ a0);
            end
        end
        return r ^ rk;
    endfunction

endpackage

/* rtl/csfs_if.sv */
// Valid/ready channel interfaces for frame bytes in and result items out.
// Depends on nothing.
`timescale 1ns / 1ps

interface csfs_in_if;
    logic        valid;
    logic        ready;
    logic        direction;
    logic [2:0]  protect_level;
    logic [63:0] source_ext;
    logic [31:0] seq_count;
    logic [6:0]  header_len;
    logic [6:0]  body_len;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (output valid, direction, protect_level, source_ext, seq_count,
                    header_len, body_len, data_byte, last_byte, input ready);
    modport sink (input valid, direction, protect_level, source_ext, seq_count,
                  header_len, body_len, data_byte, last_byte, output ready);
endinterface

interface csfs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] item_kind;
    logic       auth_fail;
    logic       last;

    modport source (output valid, out_byte, item_kind, auth_fail, last, input ready);
    modport sink (input valid, out_byte, item_kind, auth_fail, last, output ready);
endinterface

/* rtl/csfs_aes.sv */
// Iterative AES-128 encryption unit, one round per cycle, keys made on the fly.
// Depends on csfs_pkg.
`timescale 1ns / 1ps

module csfs_aes
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  csfs_pkg::blk_t  blk_in,
    input  csfs_pkg::blk_t  key,
    output logic            done,
    output csfs_pkg::blk_t  blk_out
);

    csfs_pkg::blk_t state_reg, state_next;
    csfs_pkg::blk_t rk_reg, rk_next;
    logic [7:0]     rcon_reg, rcon_next;
    logic [3:0]     round_reg, round_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    csfs_pkg::blk_t rk_step;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    // Data path
    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rk_reg    <= rk_next;
        rcon_reg  <= rcon_next;
    end

    // Start with the whitening key, then advance one round a cycle
    always_comb
    begin
        rk_step    = csfs_pkg::key_next(rk_reg, rcon_reg);
        state_next = state_reg;
        rk_next    = rk_reg;
        rcon_next  = rcon_reg;
        round_next = round_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            state_next = blk_in ^ key;
            rk_next    = key;
            rcon_next  = 8'h01;
            round_next = 4'd1;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            state_next = csfs_pkg::aes_round(state_reg, rk_step,
                                             round_reg == csfs_pkg::AES_ROUNDS);
            rk_next    = rk_step;
            rcon_next  = csfs_pkg::xtime(rcon_reg);
            round_next = round_reg + 4'd1;
            if (round_reg == csfs_pkg::AES_ROUNDS)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done    = done_reg;
    assign blk_out = state_reg;

endmodule

/* rtl/csfs_front.sv */
// Front part: accepts frame bytes, tracks the position in the frame and tags
// each byte as header, payload, received tag or ignored. Depends on csfs_pkg and csfs_if.
`timescale 1ns / 1ps

module csfs_front
#(
    parameter int MAX_FRAME_BYTES = 127
)
(
    input  logic               clk,
    input  logic               rst_n,
    csfs_in_if.sink            frame_in,
    input  logic               q_full,
    output logic               q_push,
    output csfs_pkg::entry_t   q_data
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);

    logic             active_reg, active_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             dir_reg;
    logic [2:0]       level_reg;
    logic [63:0]      src_reg;
    logic [31:0]      fc_reg;
    logic [6:0]       hlen_reg, plen_reg;

    logic        dir;
    logic [2:0]  level;
    logic [6:0]  hlen, plen;
    logic [8:0]  sum9, total9, pos9, h9, hp9;
    csfs_pkg::cls_t cls;
    logic [6:0]  idx;
    logic        fin;
    logic        take;

    assign take = frame_in.valid && !q_full;
    assign frame_in.ready = !q_full;

    // Frame fields: live on the opening byte, held afterwards
    always_comb
    begin
        dir   = active_reg ? dir_reg   : frame_in.direction;
        level = active_reg ? level_reg : frame_in.protect_level;
        hlen  = active_reg ? hlen_reg  : frame_in.header_len;
        plen  = active_reg ? plen_reg  : frame_in.body_len;
        pos9  = active_reg ? 9'(pos_reg) : 9'd0;
        h9    = {2'd0, hlen};
        hp9   = {2'd0, hlen} + {2'd0, plen};
        sum9  = hp9 + (dir ? {4'd0, csfs_pkg::tag_bytes(level[1:0])} : 9'd0);
        total9 = (sum9 > 9'(MAX_FRAME_BYTES)) ? 9'(MAX_FRAME_BYTES) : sum9;
        if (pos9 >= total9)
            cls = csfs_pkg::CLS_SKIP;
        else if (pos9 < h9)
            cls = csfs_pkg::CLS_HDR;
        else if (pos9 < hp9)
            cls = csfs_pkg::CLS_PAY;
        else
            cls = csfs_pkg::CLS_TAG;
        idx = (cls == csfs_pkg::CLS_PAY) ? 7'(pos9 - h9) : 7'(pos9 - hp9);
        fin = frame_in.last_byte || (pos9 + 9'd1 >= total9);
        active_next = active_reg;
        pos_next    = pos_reg;
        if (take)
        begin
            active_next = !fin;
            pos_next    = fin ? '0 : POS_W'(pos9 + 9'd1);
        end
    end

    // Queue entry for the back part
    always_comb
    begin
        q_push       = take;
        q_data.start = !active_reg;
        q_data.dir   = dir;
        q_data.level = level;
        q_data.src   = active_reg ? src_reg : frame_in.source_ext;
        q_data.fc    = active_reg ? fc_reg  : frame_in.seq_count;
        q_data.hlen  = hlen;
        q_data.plen  = plen;
        q_data.cls   = cls;
        q_data.idx   = idx;
        q_data.data  = frame_in.data_byte;
        q_data.fin   = fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pos_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            pos_reg    <= pos_next;
        end
    end

    // Capture frame fields on the opening byte
    always_ff @(posedge clk)
    begin
        if (take && !active_reg)
        begin
            dir_reg   <= frame_in.direction;
            level_reg <= frame_in.protect_level;
            src_reg   <= frame_in.source_ext;
            fc_reg    <= frame_in.seq_count;
            hlen_reg  <= frame_in.header_len;
            plen_reg  <= frame_in.body_len;
        end
    end

endmodule

/* rtl/csfs_queue.sv */
// Short queue of classified bytes between the front and back parts.
// Depends on csfs_pkg.
`timescale 1ns / 1ps

module csfs_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  csfs_pkg::entry_t  push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output csfs_pkg::entry_t  head
);

    csfs_pkg::entry_t                 slot_reg [csfs_pkg::QDEPTH];
    logic [csfs_pkg::QPTR_W-1:0]      wr_reg, rd_reg;
    logic [csfs_pkg::QPTR_W:0]        cnt_reg;

    assign full  = (cnt_reg == (csfs_pkg::QPTR_W + 1)'(csfs_pkg::QDEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = slot_reg[rd_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + csfs_pkg::QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + csfs_pkg::QPTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (csfs_pkg::QPTR_W + 1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (csfs_pkg::QPTR_W + 1)'(1);
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

endmodule

/* rtl/csfs_back.sv */
// Back part: runs CBC-MAC and counter mode over queued bytes through the shared
// AES unit and drives the result register. Depends on csfs_pkg, csfs_if and csfs_aes.
`timescale 1ns / 1ps

module csfs_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  csfs_pkg::blk_t    key,
    input  logic              q_empty,
    input  csfs_pkg::entry_t  q_head,
    output logic              q_pop,
    csfs_out_if.source        result_out
);

    csfs_pkg::bstate_t state_reg, state_next;
    csfs_pkg::entry_t  cur_reg, cur_next;
    logic              dir_reg, dir_next;
    logic [2:0]        level_reg, level_next;
    csfs_pkg::blk_t    ctr_reg, ctr_next;
    csfs_pkg::blk_t    mac_reg, mac_next;
    csfs_pkg::blk_t    ks_reg, ks_next;
    csfs_pkg::blk_t    rtag_reg, rtag_next;
    csfs_pkg::blk_t    mask_reg, mask_next;
    logic [3:0]        bc_reg, bc_next;
    logic [3:0]        fill_reg, fill_next;
    logic              ks_ok_reg, ks_ok_next;
    logic [3:0]        tag_i_reg, tag_i_next;

    logic              ov_reg, ov_next;
    logic [7:0]        ob_reg, ob_next;
    logic [1:0]        ok_reg, ok_next;
    logic              of_reg, of_next;
    logic              ol_reg, ol_next;

    logic              aes_start;
    csfs_pkg::blk_t    aes_blk;
    logic              aes_done;
    csfs_pkg::blk_t    aes_res;

    logic              slot_free;
    logic              has_tag, enc;
    logic [4:0]        m;
    logic [7:0]        alen, mlen, byte_in, pb;
    logic [3:0]        tlast;
    logic              fail;
    csfs_pkg::blk_t    b0;
    csfs_pkg::blk_t    tag_calc;

    csfs_aes u_aes
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (aes_start),
        .blk_in  (aes_blk),
        .key     (key),
        .done    (aes_done),
        .blk_out (aes_res)
    );

    assign slot_free = !ov_reg || result_out.ready;

    // Frame-wide derived values
    always_comb
    begin
        m        = csfs_pkg::tag_bytes(level_reg[1:0]);
        has_tag  = (m != 5'd0);
        enc      = has_tag && (level_reg > 3'd4);
        tlast    = 4'(m - 5'd1);
        alen     = enc ? {1'b0, cur_reg.hlen} : ({1'b0, cur_reg.hlen} + {1'b0, cur_reg.plen});
        mlen     = enc ? {1'b0, cur_reg.plen} : 8'd0;
        b0       = ctr_reg;
        b0[0]    = {1'b0, (alen != 8'd0), tlast[3:1] | {2'b00, 1'b1}, 3'b001};
        b0[14]   = 8'd0;
        b0[15]   = mlen;
        tag_calc = mac_reg ^ mask_reg;
        fail     = 1'b0;
        for (int i = 0; i < 16; i++)
            if ((5'(i) < m) && (tag_calc[i] != rtag_reg[i]))
                fail = 1'b1;
        byte_in  = cur_reg.data;
        pb       = byte_in ^ ks_reg[cur_reg.idx[3:0]];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cur_next   = cur_reg;
        dir_next   = dir_reg;
        level_next = level_reg;
        ctr_next   = ctr_reg;
        mac_next   = mac_reg;
        ks_next    = ks_reg;
        rtag_next  = rtag_reg;
        mask_next  = mask_reg;
        bc_next    = bc_reg;
        fill_next  = fill_reg;
        ks_ok_next = ks_ok_reg;
        tag_i_next = tag_i_reg;
        q_pop      = 1'b0;
        aes_start  = 1'b0;
        aes_blk    = mac_reg;
        ov_next    = ov_reg && !result_out.ready;
        ob_next    = ob_reg;
        ok_next    = ok_reg;
        of_next    = of_reg;
        ol_next    = ol_reg;

        case (state_reg)
            csfs_pkg::ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    state_next = csfs_pkg::ST_BYTE;
                    if (q_head.start)
                    begin
                        dir_next   = q_head.dir;
                        level_next = q_head.level;
                        ctr_next   = csfs_pkg::make_ctr(q_head.src, q_head.fc,
                                                        q_head.level, 16'd0);
                        mac_next   = '0;
                        ks_next    = '0;
                        rtag_next  = '0;
                        bc_next    = '0;
                        fill_next  = '0;
                        ks_ok_next = 1'b0;
                        if (q_head.level[1:0] != 2'd0)
                        begin
                            aes_start  = 1'b1;
                            aes_blk    = csfs_pkg::make_ctr(q_head.src, q_head.fc,
                                                            q_head.level, 16'd0);
                            state_next = csfs_pkg::ST_MASK;
                        end
                    end
                end
            end

            // Tag mask, then the first MAC block
            csfs_pkg::ST_MASK:
            begin
                if (aes_done)
                begin
                    mask_next  = aes_res;
                    aes_start  = 1'b1;
                    aes_blk    = b0;
                    state_next = csfs_pkg::ST_B0;
                end
            end

            csfs_pkg::ST_B0:
            begin
                if (aes_done)
                begin
                    mac_next = aes_res;
                    if (alen != 8'd0)
                    begin
                        mac_next[1] = aes_res[1] ^ alen;
                        fill_next   = 4'd2;
                    end
                    state_next = csfs_pkg::ST_BYTE;
                end
            end

            csfs_pkg::ST_BYTE:
            begin
                case (cur_reg.cls)
                    csfs_pkg::CLS_HDR,
                    csfs_pkg::CLS_PAY:
                    begin
                        if (enc && cur_reg.cls == csfs_pkg::CLS_PAY &&
                            cur_reg.idx == 7'd0 && fill_reg != 4'd0)
                        begin
                            // Close the header part of the MAC
                            aes_start  = 1'b1;
                            aes_blk    = mac_reg;
                            state_next = csfs_pkg::ST_FLUSH;
                        end
                        else if (enc && cur_reg.cls == csfs_pkg::CLS_PAY &&
                                 cur_reg.idx[3:0] == 4'd0 && !ks_ok_reg)
                        begin
                            // Fetch the next keystream block
                            bc_next    = bc_reg + 4'd1;
                            aes_start  = 1'b1;
                            aes_blk    = ctr_reg;
                            aes_blk[15] = {4'd0, bc_reg + 4'd1};
                            state_next = csfs_pkg::ST_KS;
                        end
                        else if (slot_free)
                        begin
                            ov_next    = 1'b1;
                            ok_next    = csfs_pkg::KIND_FRAME;
                            of_next    = 1'b0;
                            ol_next    = cur_reg.fin && !has_tag && !dir_reg;
                            ks_ok_next = 1'b0;
                            if (enc && cur_reg.cls == csfs_pkg::CLS_PAY)
                                ob_next = pb;
                            else
                                ob_next = byte_in;
                            state_next = cur_reg.fin ? csfs_pkg::ST_FIN : csfs_pkg::ST_IDLE;
                            if (has_tag)
                            begin
                                mac_next[fill_reg] = mac_reg[fill_reg] ^
                                    ((enc && cur_reg.cls == csfs_pkg::CLS_PAY && dir_reg)
                                     ? pb : byte_in);
                                if (fill_reg == 4'd15)
                                begin
                                    fill_next  = 4'd0;
                                    aes_start  = 1'b1;
                                    aes_blk    = mac_next;
                                    state_next = csfs_pkg::ST_MACW;
                                end
                                else
                                begin
                                    fill_next = fill_reg + 4'd1;
                                end
                            end
                        end
                    end
                    csfs_pkg::CLS_TAG:
                    begin
                        rtag_next[cur_reg.idx[3:0]] = byte_in;
                        state_next = cur_reg.fin ? csfs_pkg::ST_FIN : csfs_pkg::ST_IDLE;
                    end
                    default:
                    begin
                        state_next = cur_reg.fin ? csfs_pkg::ST_FIN : csfs_pkg::ST_IDLE;
                    end
                endcase
            end

            csfs_pkg::ST_FLUSH:
            begin
                if (aes_done)
                begin
                    mac_next   = aes_res;
                    fill_next  = 4'd0;
                    state_next = csfs_pkg::ST_BYTE;
                end
            end

            csfs_pkg::ST_KS:
            begin
                if (aes_done)
                begin
                    ks_next    = aes_res;
                    ks_ok_next = 1'b1;
                    state_next = csfs_pkg::ST_BYTE;
                end
            end

            csfs_pkg::ST_MACW:
            begin
                if (aes_done)
                begin
                    mac_next   = aes_res;
                    state_next = cur_reg.fin ? csfs_pkg::ST_FIN : csfs_pkg::ST_IDLE;
                end
            end

            // Close the MAC over a partial block if one is open, then go on to the verdict or tag
            csfs_pkg::ST_FIN:
            begin
                if (has_tag && fill_reg != 4'd0)
                begin
                    fill_next  = 4'd0;
                    aes_start  = 1'b1;
                    aes_blk    = mac_reg;
                    state_next = csfs_pkg::ST_FINW;
                end
                else if (dir_reg)
                    state_next = csfs_pkg::ST_VERD;
                else if (has_tag)
                begin
                    tag_i_next = 4'd0;
                    state_next = csfs_pkg::ST_TAG;
                end
                else
                    state_next = csfs_pkg::ST_IDLE;
            end

            csfs_pkg::ST_FINW:
            begin
                if (aes_done)
                begin
                    mac_next   = aes_res;
                    tag_i_next = 4'd0;
                    state_next = dir_reg ? csfs_pkg::ST_VERD : csfs_pkg::ST_TAG;
                end
            end

            csfs_pkg::ST_TAG:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = tag_calc[tag_i_reg];
                    ok_next    = csfs_pkg::KIND_TAG;
                    of_next    = 1'b0;
                    ol_next    = (tag_i_reg == tlast);
                    tag_i_next = tag_i_reg + 4'd1;
                    if (tag_i_reg == tlast)
                        state_next = csfs_pkg::ST_IDLE;
                end
            end

            csfs_pkg::ST_VERD:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    ob_next    = 8'd0;
                    ok_next    = csfs_pkg::KIND_VERDICT;
                    of_next    = fail;
                    ol_next    = 1'b1;
                    state_next = csfs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = csfs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csfs_pkg::ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // Frame working state and result payload
    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        dir_reg   <= dir_next;
        level_reg <= level_next;
        ctr_reg   <= ctr_next;
        mac_reg   <= mac_next;
        ks_reg    <= ks_next;
        rtag_reg  <= rtag_next;
        mask_reg  <= mask_next;
        bc_reg    <= bc_next;
        fill_reg  <= fill_next;
        ks_ok_reg <= ks_ok_next;
        tag_i_reg <= tag_i_next;
        ob_reg    <= ob_next;
        ok_reg    <= ok_next;
        of_reg    <= of_next;
        ol_reg    <= ol_next;
    end

    assign result_out.valid     = ov_reg;
    assign result_out.out_byte  = ob_reg;
    assign result_out.item_kind = ok_reg;
    assign result_out.auth_fail = of_reg;
    assign result_out.last      = ol_reg;

endmodule

/* rtl/ccm_star_frame_security.sv */
// Path: a frame byte passes through the queue and the back part's current-byte
// register to the result register; the first byte of a tagged frame also waits
// for the tag mask and first MAC block. Bytes go one at a time, held by the shared
// AES unit per 16 MAC bytes and keystream block; tag bytes go one a cycle if ready.
// Reset: rst_n clears the key registers and all control state at once.
`timescale 1ns / 1ps

module ccm_star_frame_security
#(
    parameter int MAX_FRAME_BYTES = 127
)
(
    input  logic        clk,
    input  logic        rst_n,
    csfs_in_if.sink     frame_in,
    csfs_out_if.source  result_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]      key_high_reg, key_low_reg;
    logic             cfg_wr;
    logic             q_push, q_pop, q_full, q_empty;
    csfs_pkg::entry_t q_in, q_head;
    csfs_pkg::blk_t   key;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == csfs_pkg::REG_KEY_LOW) ? key_low_reg : key_high_reg;
    assign key    = {key_high_reg, key_low_reg};

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == csfs_pkg::REG_KEY_HIGH)
                key_high_reg <= pwdata;
            else
                key_low_reg <= pwdata;
        end
    end

    csfs_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .frame_in (frame_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    csfs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    csfs_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .result_out (result_out)
    );

endmodule

/* rtl/csfs_checker.sv */
// Port-level checks on the result channel of the frame security block,
// attached by bind. Depends on csfs_pkg.
`timescale 1ns / 1ps

module csfs_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] item_kind,
    input logic       auth_fail,
    input logic       last
);

    // Verdict carries a zero byte and closes the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind == csfs_pkg::KIND_VERDICT |-> out_byte == 8'd0 && last)
        else $error("verdict item malformed");

    // Failure flag appears only on verdicts
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_kind != csfs_pkg::KIND_VERDICT |-> !auth_fail)
        else $error("auth_fail outside verdict");

    // Item kind is one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> item_kind == csfs_pkg::KIND_FRAME || item_kind == csfs_pkg::KIND_TAG
                      || item_kind == csfs_pkg::KIND_VERDICT)
        else $error("undefined item kind");

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(item_kind)
                                    && $stable(auth_fail) && $stable(last))
        else $error("stalled result changed");

endmodule

bind ccm_star_frame_security csfs_checker u_csfs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .out_byte  (result_out.out_byte),
    .item_kind (result_out.item_kind),
    .auth_fail (result_out.auth_fail),
    .last      (result_out.last)
);
